// ----- hw/rtl/clr_pkg.sv -----
// Shared constants, opcodes and the command type for the clipped line rasterizer.
package clr_pkg;

	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 480;
	localparam int BANK_ROWS     = 256;

	localparam int COORD_W  = 17;
	localparam int ERR_W    = 18;
	localparam int PIX_W    = 9;
	localparam int OFFSET_W = 17;
	localparam int COLOR_W  = 8;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t                     opcode;
		logic                        steep;
		logic signed [COORD_W-1:0]   major_pos;
		logic signed [COORD_W-1:0]   major_end;
		logic signed [COORD_W-1:0]   minor_pos;
		logic                        minor_dir_down;
		logic        [COORD_W-1:0]   delta_major;
		logic        [COORD_W-1:0]   delta_minor;
		logic        [COLOR_W-1:0]   color;
	} cmd_t;

endpackage

// ----- hw/rtl/clr_cmd_if.sv -----
// Input channel interface carrying load and step items.
interface clr_cmd_if;
	import clr_pkg::*;

	logic               valid;
	logic               ready;
	logic               opcode;
	logic signed [15:0] start_x;
	logic signed [15:0] start_y;
	logic signed [15:0] end_x;
	logic signed [15:0] end_y;
	logic [7:0]         pen_color;

	modport source (
		output valid, opcode, start_x, start_y, end_x, end_y, pen_color,
		input  ready
	);

	modport sink (
		input  valid, opcode, start_x, start_y, end_x, end_y, pen_color,
		output ready
	);

endinterface

// ----- hw/rtl/clr_pixel_if.sv -----
// Output channel interface carrying one rasterized pixel per transfer.
interface clr_pixel_if;

	logic        valid;
	logic        ready;
	logic [8:0]  pixel_col;
	logic [8:0]  pixel_row;
	logic        visible;
	logic        fb_sector;
	logic [16:0] fb_offset;
	logic [7:0]  pixel_color;
	logic        last;

	modport source (
		output valid, pixel_col, pixel_row, visible, fb_sector, fb_offset, pixel_color, last,
		input  ready
	);

	modport sink (
		input  valid, pixel_col, pixel_row, visible, fb_sector, fb_offset, pixel_color, last,
		output ready
	);

endinterface

// ----- hw/rtl/clr_front.sv -----
// Front end: accepts items, computes differences and classifies each line for the walk.
module clr_front
	import clr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	clr_cmd_if.sink    cmd,
	output logic       wr_valid,
	input  logic       wr_ready,
	output cmd_t       wr_data
);

	logic                      valid_s1;
	opcode_t                   opcode_s1;
	logic signed [COORD_W-1:0] x0_s1;
	logic signed [COORD_W-1:0] y0_s1;
	logic signed [COORD_W-1:0] x1_s1;
	logic signed [COORD_W-1:0] y1_s1;
	logic signed [COORD_W-1:0] dx_s1;
	logic signed [COORD_W-1:0] dy_s1;
	logic [COLOR_W-1:0]        color_s1;

	logic                      take;
	logic signed [COORD_W-1:0] ext_x0;
	logic signed [COORD_W-1:0] ext_y0;
	logic signed [COORD_W-1:0] ext_x1;
	logic signed [COORD_W-1:0] ext_y1;
	logic        [COORD_W-1:0] adx;
	logic        [COORD_W-1:0] ady;
	logic                      steep;
	logic                      swap;
	logic signed [COORD_W-1:0] minor_diff;

	assign cmd.ready = !valid_s1 || wr_ready;
	assign take      = cmd.valid && cmd.ready;

	assign ext_x0 = COORD_W'(cmd.start_x);
	assign ext_y0 = COORD_W'(cmd.start_y);
	assign ext_x1 = COORD_W'(cmd.end_x);
	assign ext_y1 = COORD_W'(cmd.end_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			opcode_s1 <= opcode_t'(cmd.opcode);
			x0_s1     <= ext_x0;
			y0_s1     <= ext_y0;
			x1_s1     <= ext_x1;
			y1_s1     <= ext_y1;
			dx_s1     <= ext_x1 - ext_x0;
			dy_s1     <= ext_y1 - ext_y0;
			color_s1  <= cmd.pen_color;
		end
	end

	always_comb begin
		adx        = dx_s1[COORD_W-1] ? COORD_W'(-dx_s1) : COORD_W'(dx_s1);
		ady        = dy_s1[COORD_W-1] ? COORD_W'(-dy_s1) : COORD_W'(dy_s1);
		steep      = ady > adx;
		swap       = steep ? dy_s1[COORD_W-1] : dx_s1[COORD_W-1];
		minor_diff = steep ? dx_s1 : dy_s1;

		wr_data.opcode      = opcode_s1;
		wr_data.steep       = steep;
		wr_data.color       = color_s1;
		wr_data.delta_major = steep ? ady : adx;
		wr_data.delta_minor = steep ? adx : ady;
		if (steep) begin
			wr_data.major_pos = swap ? y1_s1 : y0_s1;
			wr_data.major_end = swap ? y0_s1 : y1_s1;
			wr_data.minor_pos = swap ? x1_s1 : x0_s1;
		end else begin
			wr_data.major_pos = swap ? x1_s1 : x0_s1;
			wr_data.major_end = swap ? x0_s1 : x1_s1;
			wr_data.minor_pos = swap ? y1_s1 : y0_s1;
		end
		wr_data.minor_dir_down = swap ? (minor_diff >= 0) : (minor_diff <= 0);
	end

	assign wr_valid = valid_s1;

endmodule

// ----- hw/rtl/clr_queue.sv -----
// Two-entry command queue between the front end and the walk engine.
module clr_queue
	import clr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  cmd_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output cmd_t rd_data
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign wr_ready = count_q != 2'd2;
	assign rd_valid = count_q != 2'd0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- hw/rtl/clr_back.sv -----
// Walk engine: runs the Bresenham steps and forms framebuffer addresses for each pixel.
module clr_back
	import clr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rd_valid,
	output logic       rd_ready,
	input  cmd_t       rd_data,
	clr_pixel_if.source pixel
);

	logic                      active_q;
	logic                      steep_q;
	logic signed [COORD_W-1:0] major_pos_q;
	logic signed [COORD_W-1:0] major_end_q;
	logic signed [COORD_W-1:0] minor_pos_q;
	logic                      minor_dir_down_q;
	logic        [COORD_W-1:0] delta_major_q;
	logic        [COORD_W-1:0] delta_minor_q;
	logic signed [ERR_W-1:0]   error_term_q;
	logic        [COLOR_W-1:0] line_color_q;

	logic               valid_s1;
	logic [PIX_W-1:0]   col_s1;
	logic [PIX_W-1:0]   row_s1;
	logic               vis_s1;
	logic [COLOR_W-1:0] color_s1;
	logic               last_s1;

	logic                valid_s2;
	logic [PIX_W-1:0]    col_s2;
	logic [PIX_W-1:0]    row_s2;
	logic                vis_s2;
	logic                sector_s2;
	logic [OFFSET_W-1:0] offset_s2;
	logic [COLOR_W-1:0]  color_s2;
	logic                last_s2;

	logic                      load_s2;
	logic                      free_s1;
	logic                      pop;
	logic                      do_load;
	logic                      emit;
	logic signed [COORD_W-1:0] col;
	logic signed [COORD_W-1:0] row;
	logic                      vis;
	logic                      fin;
	logic signed [ERR_W-1:0]   err_sub;
	logic signed [ERR_W-1:0]   err_next;
	logic                      sector;
	logic [PIX_W-1:0]          bank_row;
	logic [31:0]               offset_full;

	assign load_s2  = !valid_s2 || pixel.ready;
	assign free_s1  = !valid_s1 || load_s2;
	assign rd_ready = (rd_data.opcode == OP_LOAD) || !active_q || free_s1;
	assign pop      = rd_valid && rd_ready;
	assign do_load  = pop && (rd_data.opcode == OP_LOAD);
	assign emit     = pop && (rd_data.opcode == OP_STEP) && active_q;

	always_comb begin
		col = steep_q ? minor_pos_q : major_pos_q;
		row = steep_q ? major_pos_q : minor_pos_q;
		vis = (col >= 0) && (col < $signed(COORD_W'(SCREEN_WIDTH)))
			&& (row >= 0) && (row < $signed(COORD_W'(SCREEN_HEIGHT)));
		fin = major_pos_q >= major_end_q;
		err_sub  = error_term_q - $signed({1'b0, delta_minor_q});
		err_next = err_sub[ERR_W-1] ? err_sub + $signed({1'b0, delta_major_q}) : err_sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q         <= 1'b0;
			steep_q          <= 1'b0;
			major_pos_q      <= '0;
			major_end_q      <= '0;
			minor_pos_q      <= '0;
			minor_dir_down_q <= 1'b0;
			delta_major_q    <= '0;
			delta_minor_q    <= '0;
			error_term_q     <= '0;
			line_color_q     <= '0;
		end else if (do_load) begin
			active_q         <= 1'b1;
			steep_q          <= rd_data.steep;
			major_pos_q      <= rd_data.major_pos;
			major_end_q      <= rd_data.major_end;
			minor_pos_q      <= rd_data.minor_pos;
			minor_dir_down_q <= rd_data.minor_dir_down;
			delta_major_q    <= rd_data.delta_major;
			delta_minor_q    <= rd_data.delta_minor;
			error_term_q     <= ERR_W'(rd_data.delta_major >> 1);
			line_color_q     <= rd_data.color;
		end else if (emit) begin
			error_term_q <= err_next;
			if (err_sub[ERR_W-1]) begin
				minor_pos_q <= minor_dir_down_q ? minor_pos_q - COORD_W'(1)
					: minor_pos_q + COORD_W'(1);
			end
			if (fin) begin
				active_q <= 1'b0;
			end else begin
				major_pos_q <= major_pos_q + COORD_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (free_s1) begin
			valid_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			col_s1   <= vis ? col[PIX_W-1:0] : '0;
			row_s1   <= vis ? row[PIX_W-1:0] : '0;
			vis_s1   <= vis;
			color_s1 <= line_color_q;
			last_s1  <= fin;
		end
	end

	always_comb begin
		sector      = row_s1 >= PIX_W'(BANK_ROWS);
		bank_row    = sector ? row_s1 - PIX_W'(BANK_ROWS) : row_s1;
		offset_full = 32'(SCREEN_WIDTH) * 32'(bank_row) + 32'(col_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			col_s2    <= col_s1;
			row_s2    <= row_s1;
			vis_s2    <= vis_s1;
			sector_s2 <= sector;
			offset_s2 <= offset_full[OFFSET_W-1:0];
			color_s2  <= color_s1;
			last_s2   <= last_s1;
		end
	end

	assign pixel.valid       = valid_s2;
	assign pixel.pixel_col   = col_s2;
	assign pixel.pixel_row   = row_s2;
	assign pixel.visible     = vis_s2;
	assign pixel.fb_sector   = sector_s2;
	assign pixel.fb_offset   = offset_s2;
	assign pixel.pixel_color = color_s2;
	assign pixel.last        = last_s2;

endmodule

// ----- hw/rtl/clipped_line_rasterizer_unit.sv -----
// Top level of the clipped line rasterizer: front end, command queue and walk engine.
//
//   Channel  Direction  Transfer content
//   cmd      in         opcode, start_x, start_y, end_x, end_y, pen_color
//   pixel    out        pixel_col, pixel_row, visible, fb_sector, fb_offset,
//                       pixel_color, last
//
// One item is taken per cycle while ready is high; a step item reaches the pixel channel
// via the front, queue and output registers; the walk's error update sets the rate.
// Reset clears the queue, the pipeline valids and the walk state, so no line is active.
// A stall on the pixel channel fills the output stages, the two-entry queue and the front
// register before the cmd channel drops ready; load items and idle steps drain without
// an output slot.
module clipped_line_rasterizer_unit
	import clr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	clr_cmd_if.sink     cmd,
	clr_pixel_if.source pixel
);

	logic wr_valid;
	logic wr_ready;
	cmd_t wr_data;
	logic rd_valid;
	logic rd_ready;
	cmd_t rd_data;

	clr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready),
		.wr_data  (wr_data)
	);

	clr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready),
		.wr_data  (wr_data),
		.rd_valid (rd_valid),
		.rd_ready (rd_ready),
		.rd_data  (rd_data)
	);

	clr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_valid (rd_valid),
		.rd_ready (rd_ready),
		.rd_data  (rd_data),
		.pixel    (pixel)
	);

endmodule

// ----- tb/clipped_line_rasterizer_unit_tb.sv -----
// Self-checking testbench for the clipped line rasterizer: directed and random lines.
module clipped_line_rasterizer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import clr_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 12;

	typedef struct {
		opcode_t        op;
		shortint        start_x;
		shortint        start_y;
		shortint        end_x;
		shortint        end_y;
		logic [7:0]     color;
	} line_cmd_t;

	typedef struct packed {
		logic [PIX_W-1:0]    col;
		logic [PIX_W-1:0]    row;
		logic                visible;
		logic                sector;
		logic [OFFSET_W-1:0] offset;
		logic [COLOR_W-1:0]  color;
		logic                last;
	} pixel_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	clr_cmd_if   cmd_ch();
	clr_pixel_if pix_ch();

	clipped_line_rasterizer_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.pixel  (pix_ch)
	);

	int unsigned feed_idle_pct = 0;
	int unsigned stall_pct     = 0;
	int unsigned items_sent    = 0;
	int unsigned error_count   = 0;
	int unsigned cycle_count   = 0;

	pixel_t pending_pixels[$];

	bit         walk_active     = 1'b0;
	bit         walk_steep      = 1'b0;
	int         walk_major      = 0;
	int         walk_major_end  = 0;
	int         walk_minor      = 0;
	bit         walk_minor_down = 1'b0;
	int         walk_dmajor     = 0;
	int         walk_dminor     = 0;
	int         walk_err        = 0;
	logic [7:0] walk_color      = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int magnitude(input int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int clamp_coord(input int v);
		return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
	endfunction

	// Advances the line walk by one item and returns 1 when a pixel comes out.
	function automatic bit predict_pixel(input line_cmd_t c, output pixel_t px);
		int x0, y0, x1, y1, a0, b0, a1, b1, t, col, row;
		bit fin;
		px = '0;
		if (c.op == OP_LOAD) begin
			x0 = c.start_x;
			y0 = c.start_y;
			x1 = c.end_x;
			y1 = c.end_y;
			walk_steep = magnitude(y1 - y0) > magnitude(x1 - x0);
			if (walk_steep) begin
				a0 = y0; b0 = x0; a1 = y1; b1 = x1;
			end else begin
				a0 = x0; b0 = y0; a1 = x1; b1 = y1;
			end
			if (a0 > a1) begin
				t = a0; a0 = a1; a1 = t;
				t = b0; b0 = b1; b1 = t;
			end
			walk_major      = a0;
			walk_major_end  = a1;
			walk_minor      = b0;
			walk_minor_down = !(b0 < b1);
			walk_dmajor     = a1 - a0;
			walk_dminor     = magnitude(b1 - b0);
			walk_err        = walk_dmajor / 2;
			walk_color      = c.color;
			walk_active     = 1'b1;
			return 1'b0;
		end
		if (!walk_active)
			return 1'b0;
		col = walk_steep ? walk_minor : walk_major;
		row = walk_steep ? walk_major : walk_minor;
		fin = walk_major >= walk_major_end;
		if (col >= 0 && col < SCREEN_WIDTH && row >= 0 && row < SCREEN_HEIGHT) begin
			px.visible = 1'b1;
			px.col     = PIX_W'(col);
			px.row     = PIX_W'(row);
			if (row >= BANK_ROWS) begin
				px.sector = 1'b1;
				row -= BANK_ROWS;
			end
			px.offset = OFFSET_W'(SCREEN_WIDTH * row + col);
		end
		px.color = walk_color;
		px.last  = fin;
		walk_err -= walk_dminor;
		if (walk_err < 0) begin
			walk_minor += walk_minor_down ? -1 : 1;
			walk_err   += walk_dmajor;
		end
		if (fin)
			walk_active = 1'b0;
		else
			walk_major++;
		return 1'b1;
	endfunction

	task automatic send_item(input opcode_t op, input int sx, input int sy, input int ex,
			input int ey, input int color);
		line_cmd_t c;
		pixel_t    px;
		while ($urandom_range(99) < feed_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		c.op      = op;
		c.start_x = shortint'(sx);
		c.start_y = shortint'(sy);
		c.end_x   = shortint'(ex);
		c.end_y   = shortint'(ey);
		c.color   = 8'(color);
		cmd_ch.valid     <= 1'b1;
		cmd_ch.opcode    <= op;
		cmd_ch.start_x   <= c.start_x;
		cmd_ch.start_y   <= c.start_y;
		cmd_ch.end_x     <= c.end_x;
		cmd_ch.end_y     <= c.end_y;
		cmd_ch.pen_color <= c.color;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		items_sent++;
		if (predict_pixel(c, px))
			pending_pixels.push_back(px);
	endtask

	// Step items carry random values in the unused fields.
	task automatic send_steps(input int n);
		for (int i = 0; i < n; i++)
			send_item(OP_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : pixel_checker
		pixel_t want;
		if (arst_n && pix_ch.valid && pix_ch.ready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected pixel transfer col %0d row %0d last %0d",
					$time, pix_ch.pixel_col, pix_ch.pixel_row, pix_ch.last);
				error_count++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("pixel_col", want.col, pix_ch.pixel_col);
				check_field("pixel_row", want.row, pix_ch.pixel_row);
				check_field("visible", want.visible, pix_ch.visible);
				check_field("fb_sector", want.sector, pix_ch.fb_sector);
				check_field("fb_offset", want.offset, pix_ch.fb_offset);
				check_field("pixel_color", want.color, pix_ch.pixel_color);
				check_field("last", want.last, pix_ch.last);
			end
		end
		pix_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic test_step_without_line();
		send_steps(1);
	endtask

	task automatic test_single_point();
		send_item(OP_LOAD, 0, 0, 0, 0, 'hFF);
		send_steps(2);
	endtask

	task automatic test_axis_lines();
		send_item(OP_LOAD, 319, 479, 316, 479, 'h00);
		send_steps(4);
		send_item(OP_LOAD, 5, 255, 5, 257, 'h81);
		send_steps(3);
	endtask

	task automatic test_steep_offscreen();
		send_item(OP_LOAD, -1, 2, 1, -3, 'h3C);
		send_steps(6);
	endtask

	// A very long line is cut short by the next load.
	task automatic test_extreme_endpoints();
		send_item(OP_LOAD, -32768, 32767, 32767, -32768, 'h5A);
		send_steps(2);
		send_item(OP_LOAD, 320, 480, 321, 481, 'hA5);
		send_steps(2);
	endtask

	task automatic test_random_lines(input int unsigned n_items);
		int unsigned stop_at;
		int unsigned kind;
		int x0, y0, x1, y1, len, n, r;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			kind = $urandom_range(99);
			x0 = int'($urandom_range(400)) - 40;
			y0 = int'($urandom_range(560)) - 40;
			x1 = x0 + int'($urandom_range(24)) - 12;
			y1 = y0 + int'($urandom_range(24)) - 12;
			if (kind >= 65 && kind < 80) begin
				x0 = shortint'($urandom);
				y0 = shortint'($urandom);
				x1 = clamp_coord(x0 + int'($urandom_range(24)) - 12);
				y1 = clamp_coord(y0 + int'($urandom_range(24)) - 12);
			end else if (kind >= 80 && kind < 90) begin
				x1 = shortint'($urandom);
				y1 = shortint'($urandom);
			end else if (kind >= 90) begin
				if ($urandom_range(1))
					x1 = x0;
				else
					y1 = y0;
			end
			send_item(OP_LOAD, x0, y0, x1, y1, $urandom);
			len = ((magnitude(x1 - x0) > magnitude(y1 - y0)) ?
				magnitude(x1 - x0) : magnitude(y1 - y0)) + 1;
			r = $urandom_range(99);
			if (len > 40)
				n = $urandom_range(40);
			else if (r < 75)
				n = len;
			else if (r < 87)
				n = len + $urandom_range(1, 3);
			else
				n = $urandom_range(len - 1);
			send_steps(n);
		end
	endtask

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		cmd_ch.valid     <= 1'b0;
		cmd_ch.opcode    <= OP_LOAD;
		cmd_ch.start_x   <= '0;
		cmd_ch.start_y   <= '0;
		cmd_ch.end_x     <= '0;
		cmd_ch.end_y     <= '0;
		cmd_ch.pen_color <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		feed_idle_pct = 11;
		stall_pct     = 85;
		test_step_without_line();
		test_single_point();
		test_axis_lines();
		test_steep_offscreen();
		test_extreme_endpoints();
		test_random_lines(130);

		feed_idle_pct = 85;
		stall_pct     = 11;
		test_random_lines(130);

		feed_idle_pct = 0;
		stall_pct     = 0;
		test_random_lines(130);

		cmd_ch.valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
